// File: design/rv32_pkg.sv
// shared types, opcodes and state encoding for the rv32im execute step unit
package rv32_pkg;

    localparam int XLEN = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW = 5;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 176;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [31:0] SIGN32 = 32'h8000_0000;

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD_RET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DSTART,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic rf_read;
        logic exec;
        logic div_start;
        logic div_step;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic is_div;
        logic div_done;
    } stat_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] mem_wdata;
        logic        halt;
        logic [31:0] halt_code;
        logic        invalid;
        logic        wb_valid;
        logic [4:0]  wb_index;
        logic [31:0] wb_value;
    } result_t;

endpackage

// File: design/rv32im_execute_step_unit.sv
// top level of the rv32im execute step unit
// One transaction in gives one transaction out. An item passes through the states accept,
// register read, operand latch and multiply, execute and commit, and result hold before the next
// can be accepted. Divide and remainder add a divider load state and the run of the
// one-bit-per-cycle divider. A new item is accepted no earlier than the
// cycle after the previous result has been taken. The register file is cleared by per-entry
// valid bits at reset.
module rv32im_execute_step_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // command, instruction, pc, load_data
    input  logic [rv32_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // next_pc, mem_read, mem_write, mem_addr, mem_size, mem_wdata, halt, halt_code,
    // invalid, wb_valid, wb_index, wb_value
    output logic [rv32_pkg::M_TDATA_W-1:0]     m_tdata
);
    import rv32_pkg::*;

    ctrl_t   ctrl;
    stat_t   stat;
    result_t res;
    logic    s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    rv32_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_fire(s_fire), .m_fire(m_fire),
        .stat(stat), .ctrl(ctrl), .s_ready(s_tready), .m_valid(m_tvalid));

    rv32_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .in_command(s_tdata[0]), .in_instruction(s_tdata[32:1]),
        .in_pc(s_tdata[64:33]), .in_load_data(s_tdata[96:65]), .result(res));

    assign m_tdata = {4'd0, res.wb_value, res.wb_index, res.wb_valid, res.invalid,
                      res.halt_code, res.halt, res.mem_wdata, res.mem_size,
                      res.mem_addr, res.mem_write, res.mem_read, res.next_pc};
endmodule

// File: design/rv32_ram.sv
// generic single write port ram with registered read
module rv32_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/rv32_divider.sv
// radix-2 restoring divider, one quotient bit per cycle while step is high
module rv32_divider (
    input  logic        aclk,
    input  logic        start,
    input  logic        step,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic [31:0] remainder,
    output logic        done
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    always_comb begin
        trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        if (step && cnt_reg != 6'd0) begin
            if (!trial[32]) begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
            cnt_reg <= 6'd32;
        end else begin
            q_reg <= q_next;
            r_reg <= r_next;
            cnt_reg <= cnt_next;
        end
    end

    assign quotient = q_reg;
    assign remainder = r_reg;
    assign done = (cnt_reg == 6'd0);
endmodule

// File: design/rv32_datapath.sv
// decode, register file, alu, multiplier and divider of the execute step
module rv32_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rv32_pkg::ctrl_t          ctrl,
    output rv32_pkg::stat_t          stat,
    input  logic                     in_command,
    input  logic [31:0]              in_instruction,
    input  logic [31:0]              in_pc,
    input  logic [31:0]              in_load_data,
    output rv32_pkg::result_t        result
);
    import rv32_pkg::*;

    logic        cmd_reg;
    logic [31:0] inst_reg, pc_reg, ld_reg;
    logic        load_pending_reg;
    logic [4:0]  load_dest_reg;
    logic [2:0]  load_kind_reg;
    logic [31:0] valid_reg;
    logic [31:0] a_raw, b_raw, c_raw, a, b, a0;
    logic        a_ok_reg, b_ok_reg, c_ok_reg;
    logic [31:0] a_reg, b_reg;
    result_t     res_reg, res_next;
    logic        pend_next;
    logic [4:0]  dest_next;
    logic [2:0]  kind_next;
    logic        wen;
    logic [31:0] mul_reg;
    logic        neg_q_reg, neg_r_reg;
    logic        div_go;
    logic [31:0] dq, dr, div_a, div_b;
    logic        div_done;

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi, imms, immb, immu, immj, pc4, v;
    logic        bad, take, wb, slt, sltu;
    logic [63:0] prod;
    logic [32:0] mx, my;
    logic [65:0] prod_s;

    assign op = inst_reg[6:0];
    assign rd = inst_reg[11:7];
    assign f3 = inst_reg[14:12];
    assign f7 = inst_reg[31:25];
    assign immi = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imms = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign immb = {{19{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                   inst_reg[11:8], 1'b0};
    assign immu = {inst_reg[31:12], 12'h000};
    assign immj = {{11{inst_reg[31]}}, inst_reg[31], inst_reg[19:12], inst_reg[20],
                   inst_reg[30:21], 1'b0};
    assign pc4 = pc_reg + 32'd4;

    // three read ports from banked copies, entries not yet written read zero
    rv32_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .aclk(aclk), .we(wen), .waddr(res_next.wb_index), .wdata(res_next.wb_value),
        .raddr(inst_reg[19:15]), .rdata(a_raw));
    rv32_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .aclk(aclk), .we(wen), .waddr(res_next.wb_index), .wdata(res_next.wb_value),
        .raddr(inst_reg[24:20]), .rdata(b_raw));
    rv32_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_c (
        .aclk(aclk), .we(wen), .waddr(res_next.wb_index), .wdata(res_next.wb_value),
        .raddr(5'd10), .rdata(c_raw));

    assign a = a_ok_reg ? a_raw : '0;
    assign b = b_ok_reg ? b_raw : '0;
    assign a0 = c_ok_reg ? c_raw : '0;

    // signed operands are taken as 33-bit values, product registered in the operand cycle
    assign mx = {(f3 != 3'd3) & a[31], a};
    assign my = {(f3 == 3'd1) & b[31], b};
    assign prod_s = $signed(mx) * $signed(my);
    assign prod = prod_s[63:0];

    assign div_a = (!f3[0] && a_reg[31]) ? (32'd0 - a_reg) : a_reg;
    assign div_b = (!f3[0] && b_reg[31]) ? (32'd0 - b_reg) : b_reg;
    assign div_go = ctrl.div_start;

    rv32_divider u_div (
        .aclk(aclk), .start(div_go), .step(ctrl.div_step), .dividend(div_a),
        .divisor(div_b), .quotient(dq), .remainder(dr), .done(div_done));

    assign stat.is_div = (cmd_reg == CMD_EXEC) && (op == OP_REG) && (f7 == 7'd1) && f3[2];
    assign stat.div_done = div_done;

    assign slt = (a_reg ^ SIGN32) < (b_reg ^ SIGN32);
    assign sltu = a_reg < b_reg;

    always_comb begin
        res_next = '0;
        pend_next = load_pending_reg;
        dest_next = load_dest_reg;
        kind_next = load_kind_reg;
        bad = 1'b0;
        take = 1'b0;
        wb = 1'b0;
        v = '0;
        if (cmd_reg == CMD_LOAD_RET) begin
            if (load_pending_reg) begin
                case (load_kind_reg)
                    3'd0: v = {{24{ld_reg[7]}}, ld_reg[7:0]};
                    3'd1: v = {{16{ld_reg[15]}}, ld_reg[15:0]};
                    3'd4: v = {24'd0, ld_reg[7:0]};
                    3'd5: v = {16'd0, ld_reg[15:0]};
                    default: v = ld_reg;
                endcase
                wb = 1'b1;
                res_next.wb_index = load_dest_reg;
                pend_next = 1'b0;
            end
        end else begin
            pend_next = 1'b0;
            res_next.next_pc = pc4;
            res_next.wb_index = rd;
            case (op)
                OP_REG: begin
                    if (f7 == 7'd0) begin
                        wb = 1'b1;
                        case (f3)
                            3'd0: v = a_reg + b_reg;
                            3'd1: v = a_reg << b_reg[4:0];
                            3'd2: v = {31'd0, slt};
                            3'd3: v = {31'd0, sltu};
                            3'd4: v = a_reg ^ b_reg;
                            3'd5: v = a_reg >> b_reg[4:0];
                            3'd6: v = a_reg | b_reg;
                            default: v = a_reg & b_reg;
                        endcase
                    end else if (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) begin
                        wb = 1'b1;
                        v = (f3 == 3'd0) ? a_reg - b_reg
                                         : 32'($signed(a_reg) >>> b_reg[4:0]);
                    end else if (f7 == 7'd1) begin
                        wb = 1'b1;
                        case (f3)
                            3'd0: v = mul_reg;
                            3'd1, 3'd2, 3'd3: v = mul_reg;
                            3'd4, 3'd5: v = (b_reg == 0) ? 32'hffff_ffff
                                          : (neg_q_reg ? 32'd0 - dq : dq);
                            default: v = (b_reg == 0) ? a_reg
                                          : (neg_r_reg ? 32'd0 - dr : dr);
                        endcase
                    end else begin
                        bad = 1'b1;
                    end
                end
                OP_IMM: begin
                    wb = 1'b1;
                    case (f3)
                        3'd0: v = a_reg + immi;
                        3'd2: v = {31'd0, (a_reg ^ SIGN32) < (immi ^ SIGN32)};
                        3'd3: v = {31'd0, a_reg < immi};
                        3'd4: v = a_reg ^ immi;
                        3'd6: v = a_reg | immi;
                        3'd7: v = a_reg & immi;
                        3'd1: begin
                            v = a_reg << immi[4:0];
                            if (f7 != 7'd0) begin
                                bad = 1'b1;
                                wb = 1'b0;
                            end
                        end
                        default: begin
                            if (f7 == 7'd0) begin
                                v = a_reg >> immi[4:0];
                            end else if (f7 == 7'h20) begin
                                v = 32'($signed(a_reg) >>> immi[4:0]);
                            end else begin
                                bad = 1'b1;
                                wb = 1'b0;
                            end
                        end
                    endcase
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 > 3'd5) begin
                        bad = 1'b1;
                    end else begin
                        res_next.mem_read = 1'b1;
                        res_next.mem_addr = a_reg + immi;
                        res_next.mem_size = f3[1:0];
                        pend_next = 1'b1;
                        dest_next = rd;
                        kind_next = f3;
                    end
                end
                OP_STORE: begin
                    if (f3 > 3'd2) begin
                        bad = 1'b1;
                    end else begin
                        res_next.mem_write = 1'b1;
                        res_next.mem_addr = a_reg + imms;
                        res_next.mem_size = f3[1:0];
                        res_next.mem_wdata = b_reg;
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        3'd0: take = (a_reg == b_reg);
                        3'd1: take = (a_reg != b_reg);
                        3'd4: take = slt;
                        3'd5: take = !slt;
                        3'd6: take = sltu;
                        3'd7: take = !sltu;
                        default: bad = 1'b1;
                    endcase
                    if (take) begin
                        res_next.next_pc = pc_reg + immb;
                    end
                end
                OP_JAL: begin
                    res_next.next_pc = pc_reg + immj;
                    wb = 1'b1;
                    v = pc4;
                end
                OP_JALR: begin
                    if (f3 != 3'd0) begin
                        bad = 1'b1;
                    end else begin
                        res_next.next_pc = (a_reg + immi) & ~32'd1;
                        wb = 1'b1;
                        v = pc4;
                    end
                end
                OP_LUI: begin
                    wb = 1'b1;
                    v = immu;
                end
                OP_AUIPC: begin
                    wb = 1'b1;
                    v = pc_reg + immu;
                end
                OP_SYSTEM: begin
                    if (inst_reg == EBREAK_WORD) begin
                        res_next.halt = 1'b1;
                        res_next.halt_code = a0;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: bad = 1'b1;
            endcase
            if (bad) begin
                res_next.invalid = 1'b1;
                res_next.next_pc = pc4;
                wb = 1'b0;
            end
        end
        res_next.wb_valid = wb && (res_next.wb_index != 5'd0);
        res_next.wb_value = res_next.wb_valid ? v : '0;
        if (!res_next.wb_valid) begin
            res_next.wb_index = '0;
        end
    end

    assign wen = ctrl.commit && res_next.wb_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pending_reg <= 1'b0;
            load_dest_reg <= '0;
            load_kind_reg <= '0;
            valid_reg <= '0;
            a_ok_reg <= 1'b0;
            b_ok_reg <= 1'b0;
            c_ok_reg <= 1'b0;
        end else begin
            if (ctrl.rf_read) begin
                a_ok_reg <= valid_reg[inst_reg[19:15]];
                b_ok_reg <= valid_reg[inst_reg[24:20]];
                c_ok_reg <= valid_reg[10];
            end
            if (ctrl.commit) begin
                load_pending_reg <= pend_next;
                load_dest_reg <= dest_next;
                load_kind_reg <= kind_next;
                if (wen) begin
                    valid_reg[res_next.wb_index] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= in_command;
            inst_reg <= in_instruction;
            pc_reg <= in_pc;
            ld_reg <= in_load_data;
        end
        if (ctrl.exec) begin
            a_reg <= a;
            b_reg <= b;
        end
        mul_reg <= (f3 == 3'd0) ? prod[31:0] : prod[63:32];
        if (ctrl.div_start) begin
            neg_q_reg <= !f3[0] && (a_reg[31] != b_reg[31]);
            neg_r_reg <= !f3[0] && a_reg[31];
        end
        if (ctrl.commit) begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;
endmodule

// File: design/rv32_ctrl.sv
// sequencing state machine of the execute step unit
module rv32_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_fire,
    input  logic            m_fire,
    input  rv32_pkg::stat_t stat,
    output rv32_pkg::ctrl_t ctrl,
    output logic            s_ready,
    output logic            m_valid
);
    import rv32_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = stat.is_div ? ST_DSTART : ST_WRITE;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV: if (stat.div_done) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT: if (m_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ctrl.capture = s_fire;
            end
            ST_READ: ctrl.rf_read = 1'b1;
            ST_EXEC: begin
                ctrl.exec = 1'b1;
            end
            // divider loaded once the operands are latched
            ST_DSTART: ctrl.div_start = 1'b1;
            ST_DIV: ctrl.div_step = 1'b1;
            ST_WRITE: ctrl.commit = 1'b1;
            ST_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: design/rv32_checker.sv
// port-level checks for the execute step unit
module rv32_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [rv32_pkg::M_TDATA_W-1:0] m_tdata
);
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
    a_wb_x0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[134] |-> m_tdata[139:135] != 5'd0) else $error("x0 written");
endmodule

bind rv32im_execute_step_unit rv32_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
